[rtl/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared constants, codes and types of the threshold sorted id list.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int LIST_DEPTH  = 64;
    localparam int KEY_BITS    = 8;
    localparam int ADDR_BITS   = $clog2(LIST_DEPTH);
    localparam int CNT_BITS    = $clog2(LIST_DEPTH + 1);

    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 32;
    localparam int THR_BITS    = 8;
    localparam int POS_BITS    = 6;
    localparam int STATUS_BITS = 2;
    localparam int ECNT_BITS   = 7;

    localparam int IN_BITS      = OP_BITS + ID_BITS + THR_BITS + POS_BITS;
    localparam int OUT_BITS     = STATUS_BITS + ID_BITS + THR_BITS + ECNT_BITS + 1;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int ENTRY_BITS   = ID_BITS + KEY_BITS;

    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_WALK  = 6'b000010,
        S_INS_PUT   = 6'b000100,
        S_DEL_SRCH  = 6'b001000,
        S_DEL_SHIFT = 6'b010000,
        S_RD_WAIT   = 6'b100000
    } t_state_base;

endpackage

[rtl/tsl_ram.sv]
// ----------------------------------------------------------------------------
// tsl_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/threshold_sorted_id_list.sv]
// ----------------------------------------------------------------------------
// threshold_sorted_id_list
// Insert walks back from the tail (one entry per cycle on the RAM port), delete
// scans from the head then shifts, read waits on the registered RAM read; insert
// into an empty or full list and a delete or read rejected at accept reply directly
// from idle. Throughput: one transaction at a time; the next is accepted after the
// reply moves into the output register.
// Reset clears the entry count and control; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module threshold_sorted_id_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation, query_id, threshold, position
    input  logic [tsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, out_id, out_threshold, entry_count, list_empty
    output logic [tsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import tsl_pkg::*;

    typedef t_state_base t_state;

    t_state                  r_state, n_state;
    logic [CNT_BITS-1:0]     r_count, n_count;
    logic [ADDR_BITS-1:0]    r_j, n_j;
    logic [ADDR_BITS-1:0]    r_addr, n_addr;
    logic [ID_BITS-1:0]      r_id, n_id;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [STATUS_BITS-1:0]  r_status, n_status;
    logic [ID_BITS-1:0]      r_res_id, n_res_id;
    logic [KEY_BITS-1:0]     r_res_key, n_res_key;
    logic                    r_done, n_done;
    logic                    r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data, n_m_data;

    logic [OP_BITS-1:0]      w_in_op;
    logic [ID_BITS-1:0]      w_in_id;
    logic [KEY_BITS-1:0]     w_in_key;
    logic [POS_BITS-1:0]     w_in_pos;

    logic                    w_we;
    logic [ADDR_BITS-1:0]    w_waddr;
    t_entry                  w_wdata;
    logic [ADDR_BITS-1:0]    w_raddr;
    t_entry                  w_rdata;
    logic                    w_head;
    logic                    w_last;
    logic                    w_load;

    assign w_in_op  = s_axis_tdata[OP_BITS-1:0];
    assign w_in_id  = s_axis_tdata[OP_BITS +: ID_BITS];
    assign w_in_key = s_axis_tdata[OP_BITS + ID_BITS +: KEY_BITS];
    assign w_in_pos = s_axis_tdata[OP_BITS + ID_BITS + THR_BITS +: POS_BITS];

    tsl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_head = (r_j == ADDR_BITS'(1));
    assign w_last = ((CNT_BITS'(r_addr) + CNT_BITS'(1)) == r_count);
    assign w_load = r_done && (!r_m_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE) && !r_done;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_addr    = r_addr;
        n_id      = r_id;
        n_key     = r_key;
        n_status  = r_status;
        n_res_id  = r_res_id;
        n_res_key = r_res_key;
        n_done    = r_done;
        w_we      = 1'b0;
        w_waddr   = r_j;
        w_wdata   = '{id: r_id, key: r_key};
        w_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_id      = w_in_id;
                    n_key     = w_in_key;
                    n_status  = ST_OK;
                    n_res_id  = '0;
                    n_res_key = '0;
                    case (w_in_op)
                        OP_INSERT: begin
                            if (r_count == CNT_BITS'(LIST_DEPTH)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = '{id: w_in_id, key: w_in_key};
                                n_count = r_count + CNT_BITS'(1);
                                n_done  = 1'b1;
                            end else begin
                                w_raddr = ADDR_BITS'(r_count - CNT_BITS'(1));
                                n_j     = ADDR_BITS'(r_count);
                                n_state = S_INS_WALK;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_done   = 1'b1;
                            end else begin
                                w_raddr = '0;
                                n_addr  = '0;
                                n_state = S_DEL_SRCH;
                            end
                        end
                        OP_READ: begin
                            if (32'(w_in_pos) >= 32'(r_count)) begin
                                n_status = ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                w_raddr = ADDR_BITS'(w_in_pos);
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_WALK: begin
                if ((!w_head && (w_rdata.key > r_key)) ||
                    (w_head && (w_rdata.key >= r_key))) begin
                    n_state = S_INS_PUT;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = w_rdata;
                    n_j     = r_j - ADDR_BITS'(1);
                    if (w_head) begin
                        n_state = S_INS_PUT;
                    end else begin
                        w_raddr = r_j - ADDR_BITS'(2);
                    end
                end
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                n_count = r_count + CNT_BITS'(1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_DEL_SRCH: begin
                if (w_rdata.id == r_id) begin
                    n_res_id = r_id;
                    if (w_last) begin
                        n_count = r_count - CNT_BITS'(1);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        w_raddr = r_addr + ADDR_BITS'(1);
                        n_addr  = r_addr + ADDR_BITS'(1);
                        n_state = S_DEL_SHIFT;
                    end
                end else if (w_last) begin
                    n_status = ST_MISSING;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_raddr = r_addr + ADDR_BITS'(1);
                    n_addr  = r_addr + ADDR_BITS'(1);
                end
            end
            S_DEL_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_addr - ADDR_BITS'(1);
                w_wdata = w_rdata;
                if (w_last) begin
                    n_count = r_count - CNT_BITS'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = r_addr + ADDR_BITS'(1);
                    n_addr  = r_addr + ADDR_BITS'(1);
                end
            end
            S_RD_WAIT: begin
                n_res_id  = w_rdata.id;
                n_res_key = w_rdata.key;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_done = 1'b0;
        end
    end

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (w_load) begin
            n_m_valid = 1'b1;
            n_m_data  = OUT_TDATA_W'({(r_count == '0),
                                      ECNT_BITS'(r_count),
                                      THR_BITS'(r_res_key),
                                      r_res_id,
                                      r_status});
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_done    <= n_done;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_addr    <= n_addr;
        r_id      <= n_id;
        r_key     <= n_key;
        r_status  <= n_status;
        r_res_id  <= n_res_id;
        r_res_key <= n_res_key;
        r_m_data  <= n_m_data;
    end

endmodule
